### design/pst_pkg.sv
// Shared types and constants for the priority sorted table.
`default_nettype none

package pst_pkg;

  // Field widths of the request and result
  localparam int unsigned PRI_W         = 8;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned INDEX_W       = 5;
  localparam int unsigned COUNT_W       = 6;
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned DEFAULT_DEPTH = 32;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  // One table entry
  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic   do_ins;
    logic   do_del;
    entry_t item;
  } cell_cmd_t;

endpackage

`default_nettype wire

### design/pst_cell.sv
// One slot of the table: holds an entry and trades it with its neighbors.
`default_nettype none

module pst_cell (
  input  wire logic               clk_i,
  input  wire pst_pkg::cell_cmd_t cmd_i,
  input  wire logic               occupied_i,
  input  wire logic               land_i,
  input  wire logic               after_idx_i,
  input  wire logic               left_take_i,
  input  wire pst_pkg::entry_t    left_entry_i,
  input  wire pst_pkg::entry_t    right_entry_i,
  input  wire pst_pkg::entry_t    carry_i,
  output logic                    take_o,
  output pst_pkg::entry_t         carry_o,
  output pst_pkg::entry_t         entry_o
);

  pst_pkg::entry_t entry_q;
  pst_pkg::entry_t entry_d;
  logic            run_head;
  logic            swap;

  // Flag a held entry that the new priority beats
  assign take_o = occupied_i && (cmd_i.item.pri > entry_q.pri);

  // Past the insertion point the carried priority equals the left run's priority,
  // so swap only where this slot starts a lower run
  assign run_head = !left_take_i || (left_entry_i.pri != entry_q.pri);
  assign swap     = take_o && run_head;

  // Pass the displaced entry on, or let the carried one through
  assign carry_o = swap ? entry_q : carry_i;

  // Insert: take the carried entry on a swap or at the first free slot;
  // delete: shift up from the index
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.do_ins) begin
      if (swap || land_i) begin
        entry_d = carry_i;
      end
    end else if (cmd_i.do_del && after_idx_i) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

### design/priority_sorted_table_top.sv
// Priority sorted table: a chain of slot cells kept in descending priority order.
//
// Each request (insert, delete at index, read at index) is first registered;
// then every slot cell compares in parallel, the displaced entry ripples down
// the chain, and the result register loads. A new request is taken only when no
// request is in work and the result register is free or its result is taken in
// the same cycle, so a request is not taken before the last one is through the
// chain. An insert into a full table returns status 1 and leaves the table
// as it was; a delete or read at an index not below the entry count returns
// status 2. An insert exchanges the carried entry only where it is strictly
// higher, so entries of equal priority may change their relative order.
// Slots come out of reset unwritten; only occupied slots are ever read, so no
// clearing pass is needed.
`default_nettype none

module priority_sorted_table_top #(
  parameter int unsigned TABLE_DEPTH = pst_pkg::DEFAULT_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [pst_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [pst_pkg::PRI_W-1:0]    item_priority_i,
  input  wire logic [pst_pkg::TAG_W-1:0]    item_tag_i,
  input  wire logic [pst_pkg::INDEX_W-1:0]  entry_index_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [pst_pkg::STATUS_W-1:0]      status_o,
  output logic [pst_pkg::PRI_W-1:0]         out_priority_o,
  output logic [pst_pkg::TAG_W-1:0]         out_tag_o,
  output logic [pst_pkg::COUNT_W-1:0]       entry_count_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > pst_pkg::INDEX_W) ? CNT_W : pst_pkg::INDEX_W;

  // Request register
  logic                            req_busy_q;
  pst_pkg::req_e                   req_type_q;
  pst_pkg::entry_t                 req_item_q;
  logic [pst_pkg::INDEX_W-1:0]     req_idx_q;

  // Table state
  logic [CNT_W-1:0]                count_q;
  logic [CNT_W-1:0]                count_d;

  // Result register
  logic                            out_valid_q;
  pst_pkg::status_e                status_q;
  pst_pkg::status_e                status_d;
  pst_pkg::entry_t                 rd_entry_q;
  pst_pkg::entry_t                 rd_entry_d;
  logic [pst_pkg::COUNT_W-1:0]     out_count_q;

  // Chain signals
  pst_pkg::cell_cmd_t              cmd;
  pst_pkg::entry_t                 cell_entry [TABLE_DEPTH];
  pst_pkg::entry_t                 cell_carry [TABLE_DEPTH];
  logic                            cell_take  [TABLE_DEPTH];
  logic                            cell_occ   [TABLE_DEPTH];
  logic                            cell_land  [TABLE_DEPTH];
  logic                            cell_after [TABLE_DEPTH];
  pst_pkg::entry_t                 sel_entry;

  logic                            in_accept;
  logic                            out_accept;
  logic                            full;
  logic                            idx_ok;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  // Hold off a new request while one is in work or a result is stuck
  assign in_stall_o = req_busy_q || (out_valid_q && out_stall_i);

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_busy_q <= 1'b0;
    end else begin
      req_busy_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_type_q     <= pst_pkg::req_e'(req_type_i);
      req_item_q.pri <= item_priority_i;
      req_item_q.tag <= item_tag_i;
      req_idx_q      <= entry_index_i;
    end
  end

  // Range checks against the current count
  assign full   = (count_q == CNT_W'(TABLE_DEPTH));
  assign idx_ok = (CMP_W'(req_idx_q) < CMP_W'(count_q));

  // Build the command for the chain
  always_comb begin
    cmd.do_ins = req_busy_q && (req_type_q == pst_pkg::REQ_INSERT) && !full;
    cmd.do_del = req_busy_q && (req_type_q == pst_pkg::REQ_DELETE) && idx_ok;
    cmd.item   = req_item_q;
  end

  // Cell chain with per-slot occupancy, landing and delete-range flags
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    pst_pkg::entry_t left_entry;
    pst_pkg::entry_t right_entry;
    pst_pkg::entry_t carry_in;
    logic            left_take;

    assign cell_occ[g]   = (CMP_W'(g) < CMP_W'(count_q));
    assign cell_land[g]  = (CMP_W'(g) == CMP_W'(count_q));
    assign cell_after[g] = (CMP_W'(g) >= CMP_W'(req_idx_q));

    if (g == 0) begin : g_first
      assign left_take  = 1'b0;
      assign left_entry = req_item_q;
      assign carry_in   = req_item_q;
    end else begin : g_inner
      assign left_take  = cell_take[g-1];
      assign left_entry = cell_entry[g-1];
      assign carry_in   = cell_carry[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[g];
    end else begin : g_body
      assign right_entry = cell_entry[g+1];
    end

    pst_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (cell_occ[g]),
      .land_i        (cell_land[g]),
      .after_idx_i   (cell_after[g]),
      .left_take_i   (left_take),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .carry_i       (carry_in),
      .take_o        (cell_take[g]),
      .carry_o       (cell_carry[g]),
      .entry_o       (cell_entry[g])
    );
  end

  // Select the slot at the request index
  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (CMP_W'(i) == CMP_W'(req_idx_q)) begin
        sel_entry = sel_entry | cell_entry[i];
      end
    end
  end

  // Work out status, read data and the new count
  always_comb begin
    status_d   = pst_pkg::STATUS_OK;
    rd_entry_d = '0;
    count_d    = count_q;
    case (req_type_q)
      pst_pkg::REQ_INSERT: begin
        if (full) begin
          status_d = pst_pkg::STATUS_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      pst_pkg::REQ_DELETE: begin
        if (idx_ok) begin
          count_d = count_q - 1'b1;
        end else begin
          status_d = pst_pkg::STATUS_RANGE;
        end
      end
      pst_pkg::REQ_READ: begin
        if (idx_ok) begin
          rd_entry_d = sel_entry;
        end else begin
          status_d = pst_pkg::STATUS_RANGE;
        end
      end
      default: begin
        status_d = pst_pkg::STATUS_OK;
      end
    endcase
  end

  // Advance the count and the result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_busy_q) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (req_busy_q) begin
      status_q    <= status_d;
      rd_entry_q  <= rd_entry_d;
      out_count_q <= pst_pkg::COUNT_W'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_priority_o = rd_entry_q.pri;
  assign out_tag_o      = rd_entry_q.tag;
  assign entry_count_o  = out_count_q;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_busy_q |=> out_valid_q)
    else $error("request in work produced no result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_ins |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("insert did not grow the count by one");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_del |=> count_q == CNT_W'($past(count_q) - 1'b1))
    else $error("delete did not shrink the count by one");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_busy_q |-> !(out_valid_q && out_stall_i))
    else $error("result register busy while a request completes");
`endif

endmodule

`default_nettype wire

### sim/tb_top.sv
// Testbench for priority_sorted_table_top: random and directed requests checked against a sorted-table model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = pst_pkg::DEFAULT_DEPTH;
  localparam int unsigned RAND_REQS  = 400;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam logic [pst_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;  // unused request code

  typedef struct {
    logic [pst_pkg::REQ_W-1:0]   kind;
    logic [pst_pkg::PRI_W-1:0]   pri;
    logic [pst_pkg::TAG_W-1:0]   tag;
    logic [pst_pkg::INDEX_W-1:0] idx;
  } table_req_t;

  typedef struct {
    pst_pkg::status_e            status;
    logic [pst_pkg::PRI_W-1:0]   pri;
    logic [pst_pkg::TAG_W-1:0]   tag;
    logic [pst_pkg::COUNT_W-1:0] entries;
  } table_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         in_valid      = 1'b0;
  logic                         in_stall_o;
  logic [pst_pkg::REQ_W-1:0]    req_type      = '0;
  logic [pst_pkg::PRI_W-1:0]    item_priority = '0;
  logic [pst_pkg::TAG_W-1:0]    item_tag      = '0;
  logic [pst_pkg::INDEX_W-1:0]  entry_index   = '0;
  logic                         out_valid_o;
  logic                         out_stall     = 1'b0;
  logic [pst_pkg::STATUS_W-1:0] status_o;
  logic [pst_pkg::PRI_W-1:0]    out_priority_o;
  logic [pst_pkg::TAG_W-1:0]    out_tag_o;
  logic [pst_pkg::COUNT_W-1:0]  entry_count_o;

  priority_sorted_table_top #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type),
    .item_priority_i(item_priority),
    .item_tag_i     (item_tag),
    .entry_index_i  (entry_index),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_tag_o      (out_tag_o),
    .entry_count_o  (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  table_req_t    pending_reqs[$];
  table_result_t expected_results[$];
  int unsigned   reqs_queued   = 0;
  int unsigned   reqs_accepted = 0;
  int unsigned   err_count     = 0;
  int unsigned   cycle_count   = 0;
  int unsigned   gen_count     = 0;

  // Model of the table contents
  pst_pkg::entry_t slot_mem[DEPTH];
  int unsigned     slot_count = 0;

  logic        req_taken   = 1'b0;
  logic        res_taken   = 1'b0;
  int unsigned req_gap     = 0;
  int unsigned res_wait    = 0;
  logic        send_burst  = 1'b0;
  logic        recv_burst  = 1'b0;

  // Apply one request to the table model and return its result
  function automatic table_result_t apply_request(input table_req_t r);
    table_result_t   res;
    pst_pkg::entry_t carry;
    pst_pkg::entry_t held;
    int unsigned     i;
    res.status = pst_pkg::STATUS_OK;
    res.pri    = '0;
    res.tag    = '0;
    case (r.kind)
      pst_pkg::REQ_INSERT: begin
        if (slot_count >= DEPTH) begin
          res.status = pst_pkg::STATUS_FULL;
        end else begin
          carry.pri = r.pri;
          carry.tag = r.tag;
          // Carry the new entry down, swapping past lower priorities
          for (i = 0; i < slot_count; i++) begin
            if (carry.pri > slot_mem[i].pri) begin
              held        = slot_mem[i];
              slot_mem[i] = carry;
              carry       = held;
            end
          end
          slot_mem[slot_count] = carry;
          slot_count++;
        end
      end
      pst_pkg::REQ_DELETE: begin
        if (r.idx >= slot_count) begin
          res.status = pst_pkg::STATUS_RANGE;
        end else begin
          // Close the gap by moving later entries up
          for (i = r.idx; i + 1 < slot_count; i++) slot_mem[i] = slot_mem[i + 1];
          slot_count--;
        end
      end
      pst_pkg::REQ_READ: begin
        if (r.idx < slot_count) begin
          res.pri = slot_mem[r.idx].pri;
          res.tag = slot_mem[r.idx].tag;
        end else begin
          res.status = pst_pkg::STATUS_RANGE;
        end
      end
      default: ;
    endcase
    res.entries = slot_count[pst_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // Queue one request and track the entry count the stimulus will reach
  task automatic add_req(input logic [pst_pkg::REQ_W-1:0] kind, input int unsigned pri,
                         input int unsigned tag, input int unsigned idx);
    table_req_t r;
    r.kind = kind;
    r.pri  = pri[pst_pkg::PRI_W-1:0];
    r.tag  = tag[pst_pkg::TAG_W-1:0];
    r.idx  = idx[pst_pkg::INDEX_W-1:0];
    pending_reqs.push_back(r);
    reqs_queued++;
    if (kind == pst_pkg::REQ_INSERT && gen_count < DEPTH) gen_count++;
    if (kind == pst_pkg::REQ_DELETE && idx < gen_count) gen_count--;
  endtask

  // Pick an index, mostly inside the occupied range
  function automatic int unsigned pick_index();
    if (gen_count > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, gen_count - 1);
    return $urandom_range(0, 2**pst_pkg::INDEX_W - 1);
  endfunction

  // Pick a priority, often from a narrow band to force ties
  function automatic int unsigned pick_priority();
    if ($urandom_range(0, 1) == 0) return $urandom_range(126, 129);
    return $urandom_range(0, 2**pst_pkg::PRI_W - 1);
  endfunction

  // Drive requests at the falling edge; hold until taken
  always @(negedge clk_i) begin : drive_requests
    logic       next_valid;
    table_req_t nxt;
    next_valid = in_valid;
    if (rst_ni && (req_taken || !in_valid)) begin
      next_valid = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        req_type      <= nxt.kind;
        item_priority <= nxt.pri;
        item_tag      <= nxt.tag;
        entry_index   <= nxt.idx;
        next_valid = 1'b1;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        req_gap = send_burst ? 0 : $urandom_range(0, 7);
      end
    end
    in_valid <= next_valid;
  end

  // Record each accepted request and predict its result
  always @(posedge clk_i) begin : capture_requests
    table_req_t r;
    req_taken <= in_valid && !in_stall_o;
    if (rst_ni && in_valid && !in_stall_o) begin
      r.kind = req_type;
      r.pri  = item_priority;
      r.tag  = item_tag;
      r.idx  = entry_index;
      expected_results.push_back(apply_request(r));
      reqs_accepted++;
    end
  end

  // Stall the result channel for a random wait after each taken result
  always @(negedge clk_i) begin : drive_stall
    if (res_taken) begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      res_wait = recv_burst ? 0 : $urandom_range(0, 7);
    end
    if (res_wait > 0) begin
      out_stall <= 1'b1;
      res_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    table_result_t exp_res;
    res_taken <= out_valid_o && !out_stall;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result status=%0d pri=%0d tag=%0d count=%0d", $realtime,
                 status_o, out_priority_o, out_tag_o, entry_count_o);
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status) begin
          err_count++;
          $display("%0t: status expected %0d actual %0d", $realtime, exp_res.status, status_o);
        end
        if (out_priority_o !== exp_res.pri) begin
          err_count++;
          $display("%0t: out_priority expected %0d actual %0d", $realtime, exp_res.pri,
                   out_priority_o);
        end
        if (out_tag_o !== exp_res.tag) begin
          err_count++;
          $display("%0t: out_tag expected %0h actual %0h", $realtime, exp_res.tag, out_tag_o);
        end
        if (entry_count_o !== exp_res.entries) begin
          err_count++;
          $display("%0t: entry_count expected %0d actual %0d", $realtime, exp_res.entries,
                   entry_count_o);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned rand_start;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned roll;

    // Directed: empty table, extremes, ties, reads and deletes at the edges
    add_req(pst_pkg::REQ_READ, 0, 0, 0);
    add_req(pst_pkg::REQ_DELETE, 0, 0, 0);
    add_req(pst_pkg::REQ_READ, 0, 0, 31);
    add_req(REQ_SPARE, 0, 0, 0);
    add_req(pst_pkg::REQ_INSERT, 0, 16'h0000, 0);
    add_req(pst_pkg::REQ_INSERT, 255, 16'hFFFF, 0);
    add_req(pst_pkg::REQ_INSERT, 128, 16'h0001, 0);
    add_req(pst_pkg::REQ_INSERT, 128, 16'h0002, 0);
    add_req(pst_pkg::REQ_INSERT, 200, 16'hAAAA, 0);
    add_req(pst_pkg::REQ_INSERT, 0, 16'h5555, 0);
    for (i = 0; i < 7; i++) add_req(pst_pkg::REQ_READ, 0, 0, i);
    add_req(pst_pkg::REQ_DELETE, 0, 0, 2);
    add_req(pst_pkg::REQ_DELETE, 0, 0, 4);
    add_req(pst_pkg::REQ_DELETE, 0, 0, 0);
    add_req(pst_pkg::REQ_READ, 0, 0, 0);
    add_req(REQ_SPARE, 255, 16'hFFFF, 31);
    add_req(pst_pkg::REQ_DELETE, 0, 0, 31);

    // Random: alternate fill, churn and drain phases to reach full and empty
    rand_start = reqs_queued;
    phase = 0;
    while (reqs_queued < rand_start + RAND_REQS) begin
      phase_len = $urandom_range(40, 70);
      for (i = 0; i < phase_len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll == 99) begin
          add_req(REQ_SPARE, $urandom_range(0, 255), $urandom_range(0, 65535), pick_index());
        end else if ((phase % 3 == 0 && roll < 85) || (phase % 3 == 1 && roll < 40) ||
                     (phase % 3 == 2 && roll < 15)) begin
          add_req(pst_pkg::REQ_INSERT, pick_priority(), $urandom_range(0, 65535),
                  pick_index());
        end else if ((phase % 3 == 0 && roll < 90) || (phase % 3 == 1 && roll < 70) ||
                     (phase % 3 == 2 && roll < 75)) begin
          add_req(pst_pkg::REQ_DELETE, pick_priority(), $urandom_range(0, 65535),
                  pick_index());
        end else begin
          add_req(pst_pkg::REQ_READ, pick_priority(), $urandom_range(0, 65535),
                  pick_index());
        end
      end
      phase++;
    end

    // Hold reset, then release it at a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every request to be taken and every result to arrive
    while (reqs_accepted < reqs_queued || expected_results.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### priority_sorted_table_top.f
design/pst_pkg.sv
design/pst_cell.sv
design/priority_sorted_table_top.sv
sim/tb_top.sv
